/* design/assert_macros.svh */
// Assertion helper macros shared by the chunk sequencer RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside of reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds at a rising clock edge outside of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* design/i2c_tcs_pkg.sv */
// Types and command codes for the I2C transfer chunk sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package i2c_tcs_pkg;

    localparam logic [2:0] CMD_START_WR   = 3'd0;
    localparam logic [2:0] CMD_START_WRRD = 3'd1;
    localparam logic [2:0] CMD_XFER_DONE  = 3'd2;
    localparam logic [2:0] CMD_RELOAD     = 3'd3;
    localparam logic [2:0] CMD_STATUS     = 3'd4;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [6:0]  dev_addr;
        logic [15:0] tx_count;
        logic [15:0] rx_count;
        logic        stop_seen;
        logic        nack_seen;
        logic        arb_lost;
    } req_t;

    typedef struct packed {
        logic       ctrl_valid;
        logic       gen_start;
        logic       gen_stop;
        logic       dir_read;
        logic       reload;
        logic       auto_end;
        logic [7:0] chunk_bytes;
        logic [6:0] target_addr;
        logic       job_done;
        logic       job_ok;
    } rsp_t;

endpackage

`default_nettype wire

/* design/i2c_transfer_chunk_sequencer.sv */
// I2C transfer chunk sequencer: takes start, reload, transfer-complete and
// status events and issues one result per event; each transfer on req gives
// exactly one transfer on rsp. An event is registered on entry, decided by a
// single pass of logic (one 16-bit compare and subtract for the chunk split)
// and registered again on exit into the output register that drives rsp. One
// event can be taken every cycle while rsp_stall does not hold the output. The
// output register lets a new event enter while a finished result still waits on
// rsp_stall.
// Depends on i2c_tcs_pkg, i2c_tcs_core and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module i2c_transfer_chunk_sequencer
    import i2c_tcs_pkg::*;
#(
    parameter int CHUNK_MAX = 255
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    logic s1_valid_reg, s1_valid_next;
    req_t s1_item_reg;
    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg;

    logic out_ready;
    logic advance;
    rsp_t res;

    assign out_ready = !rsp_valid_reg || !rsp_stall;
    assign advance   = s1_valid_reg && out_ready;
    assign req_stall = s1_valid_reg && !out_ready;

    always_comb
    begin
        s1_valid_next  = req_stall ? s1_valid_reg : req_valid;
        rsp_valid_next = out_ready ? s1_valid_reg : rsp_valid_reg;
    end

    i2c_tcs_core #(
        .CHUNK_MAX (CHUNK_MAX)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (s1_item_reg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload: load on transfer, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
            s1_item_reg <= req;
        if (advance)
            rsp_reg <= res;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ASSERT_CLK(a_stall_needs_item, clk, rst_n, !req_stall || s1_valid_reg,
        "input stalled with empty entry register")
    `ASSERT_CLK(a_advance_fills_out, clk, rst_n, advance |=> rsp_valid_reg,
        "decided item did not reach the output register")
    `ASSERT_CLK(a_no_drop, clk, rst_n,
        (s1_valid_reg && !out_ready) |=> s1_valid_reg,
        "pending item dropped while output blocked")

endmodule

`default_nettype wire

/* design/i2c_tcs_core.sv */
// Job state (remaining counts, address, phase) and the per-item decision logic.
// Depends on i2c_tcs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module i2c_tcs_core
    import i2c_tcs_pkg::*;
#(
    parameter int CHUNK_MAX = 255
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic advance,
    input  wire req_t item,
    output rsp_t      res
);

    localparam logic [15:0] LIMIT = 16'(CHUNK_MAX);

    logic [15:0] write_left_reg, write_left_next;
    logic [15:0] read_left_reg, read_left_next;
    logic [6:0]  held_addr_reg, held_addr_next;
    logic        read_phase_reg, read_phase_next;

    logic        is_start;
    logic        take_write;
    logic [15:0] src;
    logic [15:0] chunk16;
    logic [15:0] rem;
    logic [15:0] start_read;

    // One shared chunk slice: pick the count being drained this transfer.
    always_comb
    begin
        is_start   = (item.cmd == CMD_START_WR) || (item.cmd == CMD_START_WRRD);
        take_write = (item.cmd == CMD_RELOAD) && (write_left_reg != 16'd0);
        if (is_start)
            src = item.tx_count;
        else if (take_write)
            src = write_left_reg;
        else
            src = read_left_reg;
        chunk16    = (src > LIMIT) ? LIMIT : src;
        rem        = src - chunk16;
        start_read = (item.cmd == CMD_START_WRRD) ? item.rx_count : 16'd0;
    end

    always_comb
    begin
        res             = '0;
        write_left_next = write_left_reg;
        read_left_next  = read_left_reg;
        held_addr_next  = held_addr_reg;
        read_phase_next = read_phase_reg;
        case (item.cmd)
            CMD_START_WR, CMD_START_WRRD:
            begin
                if (item.tx_count == 16'd0
                    || (item.cmd == CMD_START_WRRD && item.rx_count == 16'd0))
                begin
                    res.job_done = 1'b1;
                end
                else
                begin
                    write_left_next = rem;
                    read_left_next  = start_read;
                    held_addr_next  = item.dev_addr;
                    read_phase_next = 1'b0;
                    res.ctrl_valid  = 1'b1;
                    res.gen_start   = 1'b1;
                    res.reload      = (rem != 16'd0);
                    res.auto_end    = (rem == 16'd0) && (start_read == 16'd0);
                    res.chunk_bytes = chunk16[7:0];
                    res.target_addr = item.dev_addr;
                end
            end
            CMD_XFER_DONE, CMD_RELOAD:
            begin
                if (take_write)
                begin
                    write_left_next = rem;
                    res.ctrl_valid  = 1'b1;
                    res.dir_read    = read_phase_reg;
                    res.reload      = (rem != 16'd0);
                    res.auto_end    = (rem == 16'd0) && (read_left_reg == 16'd0);
                    res.chunk_bytes = chunk16[7:0];
                    res.target_addr = held_addr_reg;
                end
                else if (read_left_reg != 16'd0)
                begin
                    // Repeated start unless a read is already running and this is a reload.
                    read_left_next  = rem;
                    read_phase_next = 1'b1;
                    res.ctrl_valid  = 1'b1;
                    res.gen_start   = !(item.cmd == CMD_RELOAD && read_phase_reg);
                    res.dir_read    = 1'b1;
                    res.reload      = (rem != 16'd0);
                    res.auto_end    = (rem == 16'd0);
                    res.chunk_bytes = chunk16[7:0];
                    res.target_addr = held_addr_reg;
                end
                else
                begin
                    res.ctrl_valid = 1'b1;
                    res.gen_stop   = 1'b1;
                end
            end
            CMD_STATUS:
            begin
                if (item.nack_seen || item.arb_lost || item.stop_seen)
                begin
                    res.job_done    = 1'b1;
                    res.job_ok      = !(item.nack_seen || item.arb_lost);
                    write_left_next = 16'd0;
                    read_left_next  = 16'd0;
                    read_phase_next = 1'b0;
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_left_reg <= '0;
            read_left_reg  <= '0;
            held_addr_reg  <= '0;
            read_phase_reg <= 1'b0;
        end
        else if (advance)
        begin
            write_left_reg <= write_left_next;
            read_left_reg  <= read_left_next;
            held_addr_reg  <= held_addr_next;
            read_phase_reg <= read_phase_next;
        end
    end

    `ASSERT_NEVER(a_word_and_done, clk, rst_n, res.ctrl_valid && res.job_done,
        "control word and job end in one result")
    `ASSERT_NEVER(a_reload_and_end, clk, rst_n, res.reload && res.auto_end,
        "chunk marked both reload and auto end")
    `ASSERT_CLK(a_chunk_nonzero, clk, rst_n,
        !(res.ctrl_valid && !res.gen_stop) || (res.chunk_bytes != 8'd0),
        "data control word with empty chunk")
    `ASSERT_CLK(a_status_clears, clk, rst_n,
        (advance && item.cmd == CMD_STATUS && res.job_done)
            |=> (write_left_reg == 16'd0 && read_left_reg == 16'd0 && !read_phase_reg),
        "job end left counts behind")

endmodule

`default_nettype wire

/* test/tb_i2c_transfer_chunk_sequencer.sv */
// Testbench for the I2C transfer chunk sequencer: directed and random event streams
// with random stalls on both sides, checked against a cycle-free predictor.
// Depends on i2c_tcs_pkg and the i2c_transfer_chunk_sequencer RTL.
`timescale 1ns / 1ps

import i2c_tcs_pkg::*;

class control_word_board;
    localparam int CHUNK_MAX = 255;

    logic [15:0] write_left;
    logic [15:0] read_left;
    logic [6:0]  held_addr;
    logic        read_phase;
    rsp_t        pending_words[$];
    int          errors;

    function new();
        write_left = '0;
        read_left  = '0;
        held_addr  = '0;
        read_phase = 1'b0;
        errors     = 0;
    endfunction

    protected function logic [7:0] carve(inout logic [15:0] left);
        logic [15:0] c;
        c = (left > CHUNK_MAX) ? 16'(CHUNK_MAX) : left;
        left = left - c;
        return c[7:0];
    endfunction

    protected function rsp_t write_chunk();
        rsp_t w;
        w = '0;
        w.ctrl_valid  = 1'b1;
        w.chunk_bytes = carve(write_left);
        w.dir_read    = read_phase;
        w.reload      = (write_left != 0);
        w.auto_end    = (write_left == 0 && read_left == 0);
        w.target_addr = held_addr;
        return w;
    endfunction

    protected function rsp_t read_chunk();
        rsp_t w;
        w = '0;
        w.ctrl_valid  = 1'b1;
        w.chunk_bytes = carve(read_left);
        w.dir_read    = 1'b1;
        w.reload      = (read_left != 0);
        w.auto_end    = (read_left == 0);
        w.target_addr = held_addr;
        return w;
    endfunction

    protected function rsp_t read_restart();
        rsp_t w;
        w = read_chunk();
        w.gen_start = 1'b1;
        read_phase = 1'b1;
        return w;
    endfunction

    protected function rsp_t stop_only();
        rsp_t w;
        w = '0;
        w.ctrl_valid = 1'b1;
        w.gen_stop   = 1'b1;
        return w;
    endfunction

    // Work out the control word for one accepted event and queue it.
    function void note_request(req_t r);
        rsp_t w;
        w = '0;
        case (r.cmd)
            CMD_START_WR, CMD_START_WRRD:
            begin
                if (r.tx_count == 0 || (r.cmd == CMD_START_WRRD && r.rx_count == 0))
                begin
                    w.job_done = 1'b1;
                end
                else
                begin
                    write_left = r.tx_count;
                    read_left  = (r.cmd == CMD_START_WRRD) ? r.rx_count : '0;
                    held_addr  = r.dev_addr;
                    read_phase = 1'b0;
                    w = write_chunk();
                    w.gen_start = 1'b1;
                end
            end
            CMD_XFER_DONE:
            begin
                w = (read_left != 0) ? read_restart() : stop_only();
            end
            CMD_RELOAD:
            begin
                if (write_left != 0)
                    w = write_chunk();
                else if (read_left != 0)
                    w = read_phase ? read_chunk() : read_restart();
                else
                    w = stop_only();
            end
            CMD_STATUS:
            begin
                if (r.stop_seen || r.nack_seen || r.arb_lost)
                begin
                    w.job_done = 1'b1;
                    w.job_ok   = !(r.nack_seen || r.arb_lost);
                    write_left = '0;
                    read_left  = '0;
                    read_phase = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        pending_words.push_back(w);
    endfunction

    protected function void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function void check_word(rsp_t got);
        rsp_t want;
        if (pending_words.size() == 0)
        begin
            $error("control word with nothing expected: %p", got);
            errors++;
            return;
        end
        want = pending_words.pop_front();
        compare_field("ctrl_valid", want.ctrl_valid, got.ctrl_valid);
        compare_field("gen_start", want.gen_start, got.gen_start);
        compare_field("gen_stop", want.gen_stop, got.gen_stop);
        compare_field("dir_read", want.dir_read, got.dir_read);
        compare_field("reload", want.reload, got.reload);
        compare_field("auto_end", want.auto_end, got.auto_end);
        compare_field("chunk_bytes", want.chunk_bytes, got.chunk_bytes);
        compare_field("target_addr", want.target_addr, got.target_addr);
        compare_field("job_done", want.job_done, got.job_done);
        compare_field("job_ok", want.job_ok, got.job_ok);
    endfunction
endclass

module tb_i2c_transfer_chunk_sequencer;

    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam int         CHUNK_MAX    = 255;
    localparam int         ITEM_TARGET  = 850;
    localparam int         STALL_LIMIT  = 1000;
    localparam int         SETTLE_CYCLES = 20;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic rsp_stall = 1'b0;
    req_t req       = '0;
    logic req_stall;
    logic rsp_valid;
    rsp_t rsp;

    control_word_board board = new();

    int gap_pct     = 0;
    int stall_left  = 0;
    int idle_cycles = 0;
    int items_sent  = 0;

    i2c_transfer_chunk_sequencer #(
        .CHUNK_MAX(CHUNK_MAX)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always #10 clk = ~clk;

    // Collect control words, drive receiver stalls and watch for a hang.
    always @(posedge clk)
    begin
        if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
            board.check_word(rsp);

        if ((req_valid === 1'b1 && req_stall === 1'b0) ||
            (rsp_valid === 1'b1 && rsp_stall === 1'b0))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end

        if (stall_left > 0)
        begin
            rsp_stall <= 1'b1;
            stall_left--;
        end
        else if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(1, 19) - 1;
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
    end

    function automatic req_t random_req();
        req_t r;
        r.cmd       = 3'($urandom_range(CMD_START_WR, CMD_SPARE_HI));
        r.dev_addr  = 7'($urandom);
        r.tx_count  = 16'($urandom);
        r.rx_count  = 16'($urandom);
        r.stop_seen = 1'($urandom);
        r.nack_seen = 1'($urandom);
        r.arb_lost  = 1'($urandom);
        return r;
    endfunction

    function automatic req_t pack_req(logic [2:0] c, logic [6:0] a, logic [15:0] tx,
                                      logic [15:0] rx, logic stp, logic nack, logic arb);
        req_t r;
        r.cmd       = c;
        r.dev_addr  = a;
        r.tx_count  = tx;
        r.rx_count  = rx;
        r.stop_seen = stp;
        r.nack_seen = nack;
        r.arb_lost  = arb;
        return r;
    endfunction

    function automatic logic [15:0] pick_length();
        int k;
        k = $urandom_range(0, 19);
        if (k == 0)
            return 16'($urandom_range(1, 65535));
        else if (k <= 3)
            return 16'($urandom_range(CHUNK_MAX - 1, CHUNK_MAX + 1) * $urandom_range(1, 2));
        else if (k <= 6)
            return 16'($urandom_range(1, 3));
        else
            return 16'($urandom_range(1, 700));
    endfunction

    task automatic push_request(input req_t r);
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        board.note_request(r);
        if (r.cmd <= CMD_STATUS)
            items_sent++;
    endtask

    // Hold the sender until every queued control word has come back.
    task automatic wait_drain();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending_words.size() != 0);
    endtask

    task automatic run_directed();
        push_request(pack_req(CMD_START_WR, 7'h7F, 16'd0, 16'hFFFF, 1'b0, 1'b0, 1'b0));
        push_request(pack_req(CMD_START_WRRD, 7'h00, 16'd0, 16'd5, 1'b0, 1'b0, 1'b0));
        push_request(pack_req(CMD_START_WRRD, 7'h55, 16'd5, 16'd0, 1'b0, 1'b0, 1'b0));
        push_request(pack_req(CMD_START_WR, 7'h7F, 16'd1, 16'h1234, 1'b0, 1'b0, 1'b0));
        push_request(pack_req(CMD_STATUS, 7'h00, 16'd0, 16'd0, 1'b1, 1'b0, 1'b0));
        push_request(pack_req(CMD_START_WR, 7'h00, 16'hFFFF, 16'd0, 1'b0, 1'b0, 1'b0));
        push_request(pack_req(CMD_RELOAD, 7'h7F, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1));
        // nack wins over stop
        push_request(pack_req(CMD_STATUS, 7'h00, 16'd0, 16'd0, 1'b1, 1'b1, 1'b0));
        push_request(pack_req(CMD_RELOAD, 7'h00, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0));
        push_request(pack_req(CMD_XFER_DONE, 7'h00, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0));
        push_request(pack_req(CMD_START_WRRD, 7'h2A, 16'd300, 16'd256, 1'b0, 1'b0, 1'b0));
        push_request(pack_req(CMD_RELOAD, 7'h00, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0));
        push_request(pack_req(CMD_XFER_DONE, 7'h00, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0));
        push_request(pack_req(CMD_RELOAD, 7'h00, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0));
        push_request(pack_req(CMD_STATUS, 7'h00, 16'd0, 16'd0, 1'b0, 1'b0, 1'b1));
        // reload after the last write chunk turns into a read restart
        push_request(pack_req(CMD_START_WRRD, 7'h55, 16'd255, 16'hFFFF, 1'b0, 1'b0, 1'b0));
        push_request(pack_req(CMD_RELOAD, 7'h00, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0));
        push_request(pack_req(CMD_RELOAD, 7'h00, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0));
        push_request(pack_req(CMD_STATUS, 7'h7F, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1));
        push_request(pack_req(CMD_STATUS, 7'h7F, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0));
        for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
            push_request(pack_req(3'(c), 7'h7F, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1));
        push_request(pack_req(CMD_START_WR, 7'h01, 16'd256, 16'd0, 1'b0, 1'b0, 1'b0));
        push_request(pack_req(CMD_RELOAD, 7'h00, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0));
        push_request(pack_req(CMD_STATUS, 7'h00, 16'd0, 16'd0, 1'b1, 1'b0, 1'b0));
    endtask

    // One well-formed job with random content, sometimes cut short.
    task automatic run_job();
        req_t r;
        int budget;
        r = random_req();
        r.cmd = $urandom_range(0, 1) ? CMD_START_WRRD : CMD_START_WR;
        r.tx_count = pick_length();
        r.rx_count = pick_length();
        budget = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : 1000;
        if (r.tx_count > 2000 || r.rx_count > 2000)
            budget = $urandom_range(1, 6);
        push_request(r);
        while (budget > 0 && (board.write_left != 0 || board.read_left != 0))
        begin
            r = random_req();
            if (board.write_left == 0 && !board.read_phase)
                r.cmd = ($urandom_range(0, 3) == 0) ? CMD_RELOAD : CMD_XFER_DONE;
            else
                r.cmd = CMD_RELOAD;
            push_request(r);
            budget--;
        end
        if ($urandom_range(0, 7) == 0)
        begin
            r = random_req();
            r.cmd = CMD_XFER_DONE;
            push_request(r);
        end
        r = random_req();
        r.cmd       = CMD_STATUS;
        r.stop_seen = (budget > 0) || $urandom_range(0, 1);
        r.nack_seen = ($urandom_range(0, 5) == 0);
        r.arb_lost  = ($urandom_range(0, 7) == 0);
        push_request(r);
    endtask

    task automatic run_noise();
        req_t r;
        repeat ($urandom_range(1, 3))
        begin
            r = random_req();
            case ($urandom_range(0, 3))
                0:
                begin
                    r.cmd = CMD_STATUS;
                    r.stop_seen = 1'b0;
                    r.nack_seen = 1'b0;
                    r.arb_lost  = 1'b0;
                end
                1:
                begin
                    r.cmd = $urandom_range(0, 1) ? CMD_START_WRRD : CMD_START_WR;
                    if ($urandom_range(0, 1))
                        r.tx_count = '0;
                    else
                        r.rx_count = '0;
                end
                default:
                begin
                end
            endcase
            push_request(r);
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        wait_drain();

        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent > ITEM_TARGET * 85 / 100)
            begin
                gap_pct = 0;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 10;
                    default: gap_pct = 40;
                endcase
            end
            if ($urandom_range(0, 4) == 0)
                run_noise();
            else
                run_job();
            if ($urandom_range(0, 30) == 0)
                wait_drain();
        end

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending_words.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
